>>> rtl/eslm_pkg.sv
// ----------------------------------------------------------------------------
// eslm_pkg
// Shared types and constants for the edge skew latency monitor.
// ----------------------------------------------------------------------------
package eslm_pkg;

    localparam int BUTTON_COUNT = 12;
    localparam int BTN_IDX_W    = $clog2(BUTTON_COUNT);
    localparam int TS_W         = 64;
    localparam int READ_W       = 20;
    localparam int WIN_W        = 24;
    localparam int STAT_W       = 32;
    localparam int SUM_W        = 64;
    localparam int DIV_CNT_W    = 7;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(200000);
    localparam logic [STAT_W-1:0] U32_MAX      = '1;
    localparam logic signed [STAT_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [STAT_W-1:0] S32_MIN = 32'sh8000_0000;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_BTN_RD,
        ST_BTN_EV,
        ST_DIV_LAT,
        ST_DIV_READ,
        ST_OUT
    } state_t;

    // divider request from the sequencer
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [SUM_W-1:0]  dividend;
        logic [STAT_W-1:0] divisor;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [SUM_W-1:0]  quotient;
    } div_rsp_t;

endpackage

>>> rtl/eslm_if.sv
// ----------------------------------------------------------------------------
// eslm_if
// Valid/ready channels: sample input, result output, window configuration.
// ----------------------------------------------------------------------------
interface eslm_in_if;
    logic                              valid;
    logic                              ready;
    logic [eslm_pkg::TS_W-1:0]         timestamp_us;
    logic [eslm_pkg::READ_W-1:0]       read_duration_us;
    logic [eslm_pkg::BUTTON_COUNT-1:0] primary_buttons;
    logic [eslm_pkg::BUTTON_COUNT-1:0] secondary_buttons;
    modport source (output valid, timestamp_us, read_duration_us, primary_buttons,
                    secondary_buttons, input ready);
    modport sink (input valid, timestamp_us, read_duration_us, primary_buttons,
                  secondary_buttons, output ready);
endinterface

interface eslm_out_if;
    logic                              valid;
    logic                              ready;
    logic [eslm_pkg::STAT_W-1:0]        matched_count;
    logic [eslm_pkg::STAT_W-1:0]        unmatched_count;
    logic signed [eslm_pkg::STAT_W-1:0] latency_min_us;
    logic signed [eslm_pkg::STAT_W-1:0] latency_max_us;
    logic signed [eslm_pkg::STAT_W-1:0] latency_avg_us;
    logic [eslm_pkg::READ_W-1:0]        read_avg_us;
    logic [eslm_pkg::READ_W-1:0]        read_peak_us;
    modport source (output valid, matched_count, unmatched_count, latency_min_us,
                    latency_max_us, latency_avg_us, read_avg_us, read_peak_us,
                    input ready);
    modport sink (input valid, matched_count, unmatched_count, latency_min_us,
                  latency_max_us, latency_avg_us, read_avg_us, read_peak_us,
                  output ready);
endinterface

interface eslm_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [eslm_pkg::WIN_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> rtl/eslm_ram.sv
// ----------------------------------------------------------------------------
// eslm_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eslm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/eslm_div.sv
// ----------------------------------------------------------------------------
// eslm_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend magnitude.
// ----------------------------------------------------------------------------
module eslm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  eslm_pkg::div_req_t req,
    output eslm_pkg::div_rsp_t rsp
);

    localparam int SW = eslm_pkg::SUM_W;
    localparam int DW = eslm_pkg::STAT_W;

    logic [SW-1:0]                 quot_reg, quot_next;
    logic [DW:0]                   rem_reg, rem_next;
    logic [DW-1:0]                 dsr_reg, dsr_next;
    logic [eslm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          neg_reg, neg_next;
    logic [DW+1:0]                 trial;
    logic [DW:0]                   shifted;

    // loading on start, else one step of shift and subtract
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        shifted   = {rem_reg[DW-1:0], quot_reg[SW-1]};
        trial     = {1'b0, shifted} - {2'b00, dsr_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            neg_next  = req.neg;
        end
        else if (busy_reg)
        begin
            if (!trial[DW+1])
            begin
                rem_next = trial[DW:0];
                quot_next = {quot_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quot_next = {quot_reg[SW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == eslm_pkg::DIV_CNT_W'(SW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                begin
                    quot_next = -{quot_reg[SW-2:0], ~trial[DW+1]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

>>> rtl/edge_skew_latency_monitor.sv
// ----------------------------------------------------------------------------
// edge_skew_latency_monitor
// Pairs button edges of two sources and keeps skew and read statistics.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one sample item (timestamp, read duration, two button vectors).
//   out_ch : one statistics item per sample.
//   cfg_ch : writes the 24-bit match window; write only while idle.
// Each sample is handled by a sequencer: a read statistics step, then two
// steps per button (read pending times from the two time RAMs, then
// evaluate and write back), then up to two divisions on a shared bit-serial
// divider, each with start and done (latency average when a pairing was
// counted, read average unless the read count is saturated). The first
// sample skips the buttons. in_ch ready returns in the same cycle that the
// result becomes valid. The result sits in an output register; a new sample
// is accepted while it waits, and the block stalls before overwriting it if
// the receiver has not taken it.
// Reset clears valid bits, counters and statistics and loads the window with
// 200000; the pending time RAMs need no clearing since valid bits gate them.
// ----------------------------------------------------------------------------
module edge_skew_latency_monitor (
    input logic clk,
    input logic rst_n,
    eslm_in_if.sink    in_ch,
    eslm_out_if.source out_ch,
    eslm_cfg_if.sink   cfg_ch
);

    localparam int BC = eslm_pkg::BUTTON_COUNT;
    localparam int IW = eslm_pkg::BTN_IDX_W;
    localparam int TW = eslm_pkg::TS_W;
    localparam int SW = eslm_pkg::STAT_W;
    localparam int RW = eslm_pkg::READ_W;

    eslm_pkg::state_t state_reg, state_next;

    logic [eslm_pkg::WIN_W-1:0] window_reg;
    logic [TW-1:0] now_reg;
    logic [RW-1:0] took_reg;
    logic [BC-1:0] prim_reg, sec_reg, prev_p_reg, prev_s_reg;
    logic [BC-1:0] pv_reg, pv_next, sv_reg, sv_next;
    logic          first_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic signed [63:0] dsum_reg, dsum_next;
    logic [SW-1:0] mtot_reg, mtot_next, utot_reg, utot_next;
    logic signed [SW-1:0] dmin_reg, dmin_next, dmax_reg, dmax_next, davg_reg;
    logic [SW-1:0] rtot_reg;
    logic [63:0]   rsum_reg;
    logic [RW-1:0] ravg_reg, rmax_reg;
    logic          need_lat_reg, need_lat_next, need_rd_reg;
    logic          out_valid_reg;

    logic [TW-1:0] p_rdata, s_rdata;
    logic          p_we, s_we;
    logic          btn_ev;

    eslm_pkg::div_req_t dreq;
    eslm_pkg::div_rsp_t drsp;

    // per-button evaluation signals
    logic pc, sc;
    logic [TW-1:0] age_p, age_s;
    logic signed [SW-1:0] d0, d1;
    logic rec0, rec1;
    logic [SW-1:0] m1;
    logic signed [63:0] sum1;
    logic signed [SW-1:0] min1, max1;
    logic [SW-1:0] u1;
    logic pvb, svb;
    logic [63:0] abs_dsum;

    assign in_ch.ready  = (state_reg == eslm_pkg::ST_IDLE);
    assign cfg_ch.ready = 1'b1;

    // time RAMs are written only in the evaluate cycle
    assign btn_ev = (state_reg == eslm_pkg::ST_BTN_EV);

    // pending time memories
    eslm_ram #(.WIDTH(TW), .DEPTH(BC)) u_pram (
        .clk(clk), .we(p_we && btn_ev), .waddr(idx_reg), .wdata(now_reg),
        .raddr(idx_reg), .rdata(p_rdata)
    );
    eslm_ram #(.WIDTH(TW), .DEPTH(BC)) u_sram (
        .clk(clk), .we(s_we && btn_ev), .waddr(idx_reg), .wdata(now_reg),
        .raddr(idx_reg), .rdata(s_rdata)
    );

    eslm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // one button: pairing, pending updates, expiry, recording
    always_comb
    begin
        pc   = prim_reg[idx_reg] ^ prev_p_reg[idx_reg];
        sc   = sec_reg[idx_reg] ^ prev_s_reg[idx_reg];
        pvb  = pv_reg[idx_reg];
        svb  = sv_reg[idx_reg];
        age_p = now_reg - p_rdata;
        age_s = now_reg - s_rdata;
        p_we = 1'b0;
        s_we = 1'b0;
        rec0 = 1'b0;
        rec1 = 1'b0;
        d0 = '0;
        d1 = '0;
        u1 = utot_reg;
        if (pc && sc)
        begin
            rec0 = 1'b1;
            pvb  = 1'b0;
            svb  = 1'b0;
        end
        else
        begin
            if (pc)
            begin
                if (svb)
                begin
                    rec0 = 1'b1;
                    d0 = (age_s >= 64'h8000_0000) ? eslm_pkg::S32_MIN
                                                 : -$signed(age_s[SW-1:0]);
                    svb = 1'b0;
                end
                else
                begin
                    p_we = 1'b1;
                    pvb  = 1'b1;
                end
            end
            if (sc)
            begin
                if (pvb)
                begin
                    rec1 = 1'b1;
                    // fresh primary edge in this sample has age zero
                    d1 = (p_we) ? '0 :
                         (age_p > 64'h7FFF_FFFF) ? eslm_pkg::S32_MAX
                                                 : $signed(age_p[SW-1:0]);
                    pvb = 1'b0;
                end
                else
                begin
                    s_we = 1'b1;
                    svb  = 1'b1;
                end
            end
            if (pvb && !p_we && age_p > {40'd0, window_reg})
            begin
                pvb = 1'b0;
                if (u1 != eslm_pkg::U32_MAX) u1 = u1 + 1'b1;
            end
            if (svb && !s_we && age_s > {40'd0, window_reg})
            begin
                svb = 1'b0;
                if (u1 != eslm_pkg::U32_MAX) u1 = u1 + 1'b1;
            end
        end
        // at most one record per button (pc with sv excludes sc with pv)
        min1 = dmin_reg;
        max1 = dmax_reg;
        m1   = mtot_reg;
        sum1 = dsum_reg;
        if (rec0 || rec1)
        begin
            if (rec1) d0 = d1;
            if (mtot_reg == '0 || d0 < dmin_reg) min1 = d0;
            if (mtot_reg == '0 || d0 > dmax_reg) max1 = d0;
            if (mtot_reg != eslm_pkg::U32_MAX)
            begin
                m1   = mtot_reg + 1'b1;
                sum1 = dsum_reg + 64'(d0);
            end
        end
    end

    assign abs_dsum = dsum_reg[63] ? -dsum_reg : dsum_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eslm_pkg::ST_IDLE:
                if (in_ch.valid) state_next = eslm_pkg::ST_READ;
            eslm_pkg::ST_READ:
                state_next = first_reg ? eslm_pkg::ST_DIV_LAT : eslm_pkg::ST_BTN_RD;
            eslm_pkg::ST_BTN_RD:
                state_next = eslm_pkg::ST_BTN_EV;
            eslm_pkg::ST_BTN_EV:
                state_next = (idx_reg == IW'(BC - 1)) ? eslm_pkg::ST_DIV_LAT
                                                       : eslm_pkg::ST_BTN_RD;
            eslm_pkg::ST_DIV_LAT:
                if (!need_lat_reg || drsp.done) state_next = eslm_pkg::ST_DIV_READ;
            eslm_pkg::ST_DIV_READ:
                if (!need_rd_reg || drsp.done) state_next = eslm_pkg::ST_OUT;
            eslm_pkg::ST_OUT:
                if (!out_valid_reg || out_ch.ready) state_next = eslm_pkg::ST_IDLE;
            default:
                state_next = eslm_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: divider requests and per-button updates
    always_comb
    begin
        dreq = '0;
        idx_next = idx_reg;
        pv_next = pv_reg;
        sv_next = sv_reg;
        mtot_next = mtot_reg;
        utot_next = utot_reg;
        dmin_next = dmin_reg;
        dmax_next = dmax_reg;
        dsum_next = dsum_reg;
        need_lat_next = need_lat_reg;
        unique case (state_reg)
            eslm_pkg::ST_IDLE:
            begin
                idx_next = '0;
                need_lat_next = 1'b0;
            end
            eslm_pkg::ST_BTN_EV:
            begin
                pv_next[idx_reg] = pvb;
                sv_next[idx_reg] = svb;
                mtot_next = m1;
                utot_next = u1;
                dmin_next = min1;
                dmax_next = max1;
                dsum_next = sum1;
                if (m1 != mtot_reg) need_lat_next = 1'b1;
                // index stays inside the button range
                idx_next = (idx_reg == IW'(BC - 1)) ? '0 : idx_reg + 1'b1;
            end
            eslm_pkg::ST_DIV_LAT:
            begin
                if (need_lat_reg && !drsp.busy && !drsp.done)
                begin
                    dreq.start = 1'b1;
                    dreq.neg = dsum_reg[63];
                    dreq.dividend = abs_dsum;
                    dreq.divisor = mtot_reg;
                end
            end
            eslm_pkg::ST_DIV_READ:
            begin
                if (need_rd_reg && !drsp.busy && !drsp.done)
                begin
                    dreq.start = 1'b1;
                    dreq.dividend = rsum_reg;
                    dreq.divisor = rtot_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eslm_pkg::ST_IDLE;
            window_reg <= eslm_pkg::WINDOW_RESET;
            pv_reg <= '0;
            sv_reg <= '0;
            prev_p_reg <= '0;
            prev_s_reg <= '0;
            first_reg <= 1'b1;
            idx_reg <= '0;
            dsum_reg <= '0;
            mtot_reg <= '0;
            utot_reg <= '0;
            dmin_reg <= '0;
            dmax_reg <= '0;
            davg_reg <= '0;
            rtot_reg <= '0;
            rsum_reg <= '0;
            ravg_reg <= '0;
            rmax_reg <= '0;
            need_lat_reg <= 1'b0;
            need_rd_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            pv_reg <= pv_next;
            sv_reg <= sv_next;
            mtot_reg <= mtot_next;
            utot_reg <= utot_next;
            dmin_reg <= dmin_next;
            dmax_reg <= dmax_next;
            dsum_reg <= dsum_next;
            need_lat_reg <= need_lat_next;
            if (cfg_ch.valid) window_reg <= cfg_ch.data;
            if (state_reg == eslm_pkg::ST_READ)
            begin
                need_rd_reg <= (rtot_reg != eslm_pkg::U32_MAX);
                if (rtot_reg != eslm_pkg::U32_MAX)
                begin
                    rtot_reg <= rtot_reg + 1'b1;
                    rsum_reg <= rsum_reg + 64'(took_reg);
                end
                if (took_reg > rmax_reg) rmax_reg <= took_reg;
            end
            if (state_reg == eslm_pkg::ST_DIV_LAT && need_lat_reg && drsp.done)
            begin
                davg_reg <= $signed(drsp.quotient[SW-1:0]);
            end
            if (state_reg == eslm_pkg::ST_DIV_READ && need_rd_reg && drsp.done)
            begin
                ravg_reg <= drsp.quotient[RW-1:0];
            end
            if (state_reg == eslm_pkg::ST_OUT && (!out_valid_reg || out_ch.ready))
            begin
                out_valid_reg <= 1'b1;
                first_reg <= 1'b0;
                prev_p_reg <= prim_reg;
                prev_s_reg <= sec_reg;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // captured sample
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            now_reg  <= in_ch.timestamp_us;
            took_reg <= in_ch.read_duration_us;
            prim_reg <= in_ch.primary_buttons;
            sec_reg  <= in_ch.secondary_buttons;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (state_reg == eslm_pkg::ST_OUT && (!out_valid_reg || out_ch.ready))
        begin
            out_ch.matched_count   <= mtot_reg;
            out_ch.unmatched_count <= utot_reg;
            out_ch.latency_min_us  <= dmin_reg;
            out_ch.latency_max_us  <= dmax_reg;
            out_ch.latency_avg_us  <= davg_reg;
            out_ch.read_avg_us     <= ravg_reg;
            out_ch.read_peak_us    <= rmax_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;

endmodule

>>> rtl/eslm_checker.sv
// ----------------------------------------------------------------------------
// eslm_checker
// Port-level checks of the edge skew latency monitor.
// ----------------------------------------------------------------------------
module eslm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [eslm_pkg::STAT_W-1:0] matched_count,
    input logic signed [eslm_pkg::STAT_W-1:0] latency_min_us,
    input logic signed [eslm_pkg::STAT_W-1:0] latency_max_us
);

    // a result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(matched_count))
        else $error("result changed under stall");

    // a sample is never taken in the cycle after one was taken
    a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted back to back");

    // the matched count never falls between results
    a_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid && !$stable(matched_count)
        |-> matched_count >= $past(matched_count))
        else $error("matched count decreased");

    // min never exceeds max once pairings exist
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched_count != '0 |-> latency_min_us <= latency_max_us)
        else $error("min above max");

endmodule

bind edge_skew_latency_monitor eslm_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .matched_count(out_ch.matched_count),
    .latency_min_us(out_ch.latency_min_us),
    .latency_max_us(out_ch.latency_max_us)
);
